// File: rtl/min_max_heap_queue_top_assert.svh
// ----------------------------------------------------------------------------
// Min-max heap queue assertion macros
// Shorthand for clocked checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define MIN_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

// same-cycle implication
`define MMHQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMHQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mmhq_pkg.sv
// ----------------------------------------------------------------------------
// Min-max heap queue package
// Shared constants, request modes, datapath operations and status types.
// ----------------------------------------------------------------------------
package mmhq_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int OP_W         = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EXTRACT_MIN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EXTRACT_MAX = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_MIN    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_MAX    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR       = 3'd5;

  localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
  localparam logic [OP_W-1:0] OP_START    = 5'd1;
  localparam logic [OP_W-1:0] OP_ERR      = 5'd2;
  localparam logic [OP_W-1:0] OP_CLR      = 5'd3;
  localparam logic [OP_W-1:0] OP_INS      = 5'd4;
  localparam logic [OP_W-1:0] OP_RD_ROOT  = 5'd5;
  localparam logic [OP_W-1:0] OP_RES_LAST = 5'd6;
  localparam logic [OP_W-1:0] OP_LD_VAL   = 5'd7;
  localparam logic [OP_W-1:0] OP_RES_RD   = 5'd8;
  localparam logic [OP_W-1:0] OP_WR_VAL   = 5'd9;
  localparam logic [OP_W-1:0] OP_RD_PAR   = 5'd10;
  localparam logic [OP_W-1:0] OP_MOVE_UP  = 5'd11;
  localparam logic [OP_W-1:0] OP_RD_L     = 5'd12;
  localparam logic [OP_W-1:0] OP_RD_R     = 5'd13;
  localparam logic [OP_W-1:0] OP_MOVE_DN  = 5'd14;
  localparam logic [OP_W-1:0] OP_MX_INIT  = 5'd15;
  localparam logic [OP_W-1:0] OP_MX_SCAN  = 5'd16;
  localparam logic [OP_W-1:0] OP_MX_FIN   = 5'd17;
  localparam logic [OP_W-1:0] OP_MX_DEC   = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_zero;
    logic left_out;
    logic val_lt_rd;
    logic sd_go;
    logic scan_busy;
  } status_t;

endpackage

// File: rtl/mmhq_datapath.sv
// ----------------------------------------------------------------------------
// Min-max heap queue datapath
// Heap memory, hole position, moving value, leaf scan and result registers.
// ----------------------------------------------------------------------------
`include "min_max_heap_queue_top_assert.svh"

module mmhq_datapath import mmhq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cmd_t                             cmd,
  input  logic signed [DATA_W-1:0]         value,
  output status_t                          status,
  output logic signed [DATA_W-1:0]         result_value,
  output logic                             error,
  output logic [$clog2(CAPACITY+1)-1:0]    count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);

  logic signed [DATA_W-1:0] mem [CAPACITY];
  logic signed [DATA_W-1:0] rd;
  logic [AW-1:0]            raddr;
  logic                     we;
  logic signed [DATA_W-1:0] wdata;

  logic [CW-1:0]            cnt;
  logic [CW-1:0]            pos;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] lc;
  logic signed [DATA_W-1:0] res;
  logic                     err;
  logic [CW-1:0]            scan;
  logic [CW-1:0]            pidx;
  logic                     pend;
  logic                     first;
  logic [CW-1:0]            best;
  logic signed [DATA_W-1:0] bmax;

  logic [CW:0]   lidx;
  logic [CW:0]   ridx;
  logic [CW-1:0] last_idx;
  logic [CW-1:0] parent;
  logic          l_in;
  logic          r_in;
  logic          l_lt;
  logic          sel_r;
  logic          go;
  logic          scan_more;

  assign lidx      = {pos, 1'b0};
  assign ridx      = {pos, 1'b1};
  assign last_idx  = cnt - CW'(1);
  assign parent    = pos >> 1;
  assign l_in      = lidx < {1'b0, cnt};
  assign r_in      = ridx < {1'b0, cnt};
  assign scan_more = scan < cnt;

  // the hole sits at pos; node 0 is its own left child, so skip that compare
  always_comb begin
    l_lt  = (pos != '0) && (lc < val);
    sel_r = 1'b0;
    go    = 1'b0;
    if (l_lt) begin
      go    = 1'b1;
      sel_r = r_in && (lc > rd) && (val > rd);
    end else if (r_in && (rd < val)) begin
      go    = 1'b1;
      sel_r = 1'b1;
    end
  end

  always_comb begin
    status.empty     = (cnt == '0);
    status.full      = (cnt == CW'(CAPACITY));
    status.pos_zero  = (pos == '0);
    status.left_out  = !l_in;
    status.val_lt_rd = (val < rd);
    status.sd_go     = go;
    status.scan_busy = scan_more || pend;
  end

  always_comb begin
    raddr = '0;
    we    = 1'b0;
    wdata = val;
    case (cmd.op)
      OP_RD_ROOT:  raddr = '0;
      OP_RES_LAST: raddr = last_idx[AW-1:0];
      OP_MX_FIN:   raddr = last_idx[AW-1:0];
      OP_RD_PAR:   raddr = parent[AW-1:0];
      OP_RD_L:     raddr = lidx[AW-1:0];
      OP_RD_R:     raddr = ridx[AW-1:0];
      OP_MX_SCAN:  raddr = scan[AW-1:0];
      OP_WR_VAL: begin
        we    = 1'b1;
        wdata = val;
      end
      OP_MOVE_UP: begin
        we    = 1'b1;
        wdata = rd;
      end
      OP_MOVE_DN: begin
        we    = 1'b1;
        wdata = sel_r ? rd : lc;
      end
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos[AW-1:0]] <= wdata;
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      err   <= 1'b0;
      pend  <= 1'b0;
      first <= 1'b0;
    end else begin
      case (cmd.op)
        OP_START: begin
          pos <= cnt;
          val <= value;
          err <= 1'b0;
          res <= '0;
        end
        OP_ERR: begin
          err <= 1'b1;
          res <= '0;
        end
        OP_CLR:  cnt <= '0;
        OP_INS:  cnt <= cnt + CW'(1);
        OP_RES_LAST: begin
          res <= rd;
          cnt <= last_idx;
          pos <= '0;
        end
        OP_LD_VAL:  val <= rd;
        OP_RES_RD:  res <= rd;
        OP_MOVE_UP: pos <= parent;
        OP_RD_R:    lc  <= rd;
        OP_MOVE_DN: pos <= sel_r ? ridx[CW-1:0] : lidx[CW-1:0];
        OP_MX_INIT: begin
          scan  <= cnt >> 1;
          pend  <= 1'b0;
          first <= 1'b1;
        end
        OP_MX_SCAN: begin
          if (pend && (first || (rd >= bmax))) begin
            bmax  <= rd;
            best  <= pidx;
            first <= 1'b0;
          end
          if (scan_more) begin
            pidx <= scan;
            scan <= scan + CW'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
        end
        OP_MX_FIN: begin
          res <= bmax;
          pos <= best;
        end
        OP_MX_DEC: begin
          val <= rd;
          cnt <= last_idx;
        end
        default: ;
      endcase
    end
  end

  assign result_value = res;
  assign error        = err;
  assign count        = cnt;

  `MMHQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CW'(CAPACITY), "count above capacity")
  `MMHQ_ASSERT_NOW(a_ins_not_full, cmd.op == OP_INS, cnt != CW'(CAPACITY),
    "insert into full store")

endmodule

// File: rtl/mmhq_ctrl.sv
// ----------------------------------------------------------------------------
// Min-max heap queue controller
// Sequences request modes into datapath operations.
// ----------------------------------------------------------------------------
`include "min_max_heap_queue_top_assert.svh"

module mmhq_ctrl import mmhq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MODE_W-1:0] mode,
  input  status_t           status,
  output cmd_t              cmd,
  output logic              busy,
  output logic              done
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_SU_RD   = 4'd2;
  localparam logic [3:0] S_SU_CMP  = 4'd3;
  localparam logic [3:0] S_EM1     = 4'd4;
  localparam logic [3:0] S_EM2     = 4'd5;
  localparam logic [3:0] S_RM      = 4'd6;
  localparam logic [3:0] S_SD_RL   = 4'd7;
  localparam logic [3:0] S_SD_RR   = 4'd8;
  localparam logic [3:0] S_SD_CMP  = 4'd9;
  localparam logic [3:0] S_MX_SCAN = 4'd10;
  localparam logic [3:0] S_MX_FIN  = 4'd11;
  localparam logic [3:0] S_XM_DEC  = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [MODE_W-1:0] mode_q;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NOP;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_START;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (mode_q)
          MODE_INSERT: begin
            cmd.op     = status.full ? OP_ERR : OP_INS;
            state_next = status.full ? S_DONE : S_SU_RD;
          end
          MODE_EXTRACT_MIN: begin
            cmd.op     = status.empty ? OP_ERR : OP_RD_ROOT;
            state_next = status.empty ? S_DONE : S_EM1;
          end
          MODE_READ_MIN: begin
            cmd.op     = status.empty ? OP_ERR : OP_RD_ROOT;
            state_next = status.empty ? S_DONE : S_RM;
          end
          MODE_EXTRACT_MAX, MODE_READ_MAX: begin
            cmd.op     = status.empty ? OP_ERR : OP_MX_INIT;
            state_next = status.empty ? S_DONE : S_MX_SCAN;
          end
          MODE_CLEAR: begin
            cmd.op     = OP_CLR;
            state_next = S_DONE;
          end
          default: begin
            cmd.op     = OP_ERR;
            state_next = S_DONE;
          end
        endcase
      end
      S_SU_RD: begin
        cmd.op     = status.pos_zero ? OP_WR_VAL : OP_RD_PAR;
        state_next = status.pos_zero ? S_DONE : S_SU_CMP;
      end
      S_SU_CMP: begin
        cmd.op     = status.val_lt_rd ? OP_MOVE_UP : OP_WR_VAL;
        state_next = status.val_lt_rd ? S_SU_RD : S_DONE;
      end
      S_EM1: begin
        cmd.op     = OP_RES_LAST;
        state_next = S_EM2;
      end
      S_EM2: begin
        cmd.op     = OP_LD_VAL;
        state_next = status.empty ? S_DONE : S_SD_RL;
      end
      S_RM: begin
        cmd.op     = OP_RES_RD;
        state_next = S_DONE;
      end
      S_SD_RL: begin
        cmd.op     = status.left_out ? OP_WR_VAL : OP_RD_L;
        state_next = status.left_out ? S_DONE : S_SD_RR;
      end
      S_SD_RR: begin
        cmd.op     = OP_RD_R;
        state_next = S_SD_CMP;
      end
      S_SD_CMP: begin
        cmd.op     = status.sd_go ? OP_MOVE_DN : OP_WR_VAL;
        state_next = status.sd_go ? S_SD_RL : S_DONE;
      end
      S_MX_SCAN: begin
        cmd.op     = OP_MX_SCAN;
        state_next = status.scan_busy ? S_MX_SCAN : S_MX_FIN;
      end
      S_MX_FIN: begin
        cmd.op     = OP_MX_FIN;
        state_next = (mode_q == MODE_READ_MAX) ? S_DONE : S_XM_DEC;
      end
      S_XM_DEC: begin
        cmd.op     = OP_MX_DEC;
        state_next = S_SU_RD;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mode_q <= mode;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  `MMHQ_ASSERT_NEXT(a_take_busy, start && !busy, busy, "request taken but not busy")
  `MMHQ_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `MMHQ_ASSERT_NEXT(a_done_idle, done, !busy, "no return to idle after result")

endmodule

// File: rtl/min_max_heap_queue_top.sv
// Operation: insert sifts the new value up level by level; extract min returns the root, moves the
//   last entry there and sifts it down level by level; read min reads the root; read max scans the
//   leaves; extract max scans, then sifts the last entry up from the largest leaf; errors end the request.
// Requests: one at a time, the next taken in the cycle after the result; the leaf scan
//   (one memory read per cycle over the leaves) sets the worst case.
// Reset: synchronous; empties the queue, heap memory is not cleared; results cannot be stalled.
// ----------------------------------------------------------------------------
// Min-max heap queue top level
// Double-ended priority queue over a binary min-heap held in block memory.
// ----------------------------------------------------------------------------
module min_max_heap_queue_top import mmhq_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [MODE_W-1:0]             mode,
  input  logic signed [DATA_W-1:0]      value,
  output logic                          done,
  output logic signed [DATA_W-1:0]      result_value,
  output logic                          error,
  output logic [$clog2(CAPACITY+1)-1:0] count
);

  cmd_t    cmd;
  status_t status;

  mmhq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mmhq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .status       (status),
    .result_value (result_value),
    .error        (error),
    .count        (count)
  );

endmodule
